// ----- sv/mre_pkg.sv -----
// shared types and constants for the max relative error block
// no dependencies; imported by the controller, the datapath and the top level
package mre_pkg;

    // field and register widths
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned ERR_W    = 63;
    localparam int unsigned FLOOR_W  = 63;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 63;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MODE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_FLOOR = 1'b1;

    // denominator modes
    localparam logic MODE_EPSILON = 1'b0;
    localparam logic MODE_FLOOR   = 1'b1;

    // arithmetic constants
    localparam logic [VALUE_W-1:0] EPSILON_Q   = 64'd256;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 63'd256;
    localparam logic [ERR_W-1:0]   ERR_MAX     = {ERR_W{1'b1}};

    // quotient bits left once the overflow precheck has passed
    localparam int unsigned DIV_STEPS = 63;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // take the accepted request
        logic prep;     // form numerator and denominator
        logic check;    // overflow precheck and divider load
        logic step;     // one quotient bit
        logic finish;   // fold into running max, emit on last
    } mre_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sat_early;  // zero denominator or quotient overflow
        logic div_last;   // current step is the final one
        logic last_item;  // captured item closes the vector
        logic out_busy;   // output register holds an untaken result
    } mre_sts_t;

endpackage

// ----- sv/mre_ctrl.sv -----
// controller state machine for the max relative error block
// depends on mre_pkg for command and status types
module mre_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mre_pkg::mre_sts_t sts,
    output mre_pkg::mre_cmd_t cmd
);
    import mre_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_DIV,
        ST_ACC
    } state_t;

    state_t state_reg, state_next;

    // command decode from state
    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.sat_early ? ST_ACC : ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (sts.div_last) state_next = ST_ACC;
            end
            ST_ACC: begin
                // hold while this item closes the vector and a previous result still waits downstream
                if (!(sts.last_item && sts.out_busy)) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/mre_dp.sv -----
// datapath: operand preparation, 96-by-64 restoring divider, running max, result register
// depends on mre_pkg for widths, constants and command/status types
module mre_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mre_pkg::mre_cmd_t                   cmd,
    output mre_pkg::mre_sts_t                   sts,
    input  logic                                cfg_wr_en,
    input  logic [mre_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mre_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic [mre_pkg::VALUE_W-1:0]         in_sim,
    input  logic [mre_pkg::VALUE_W-1:0]         in_target,
    input  logic                                in_last,
    output logic [mre_pkg::ERR_W-1:0]           out_error,
    output logic                                out_sat,
    output logic                                out_valid,
    input  logic                                out_ready
);
    import mre_pkg::*;

    // configuration
    logic               mode_reg;
    logic [FLOOR_W-1:0] floor_reg;

    // captured request
    logic [VALUE_W-1:0] sim_reg, tgt_reg;
    logic               last_reg;

    // operands and divider
    logic [VALUE_W-1:0] num_reg, den_reg, rem_reg;
    logic [DIV_STEPS-1:0] feed_reg;
    logic [ERR_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               sat_reg;

    // accumulation and result
    logic [ERR_W-1:0]   max_reg;
    logic               seen_reg;
    logic [ERR_W-1:0]   out_error_reg;
    logic               out_sat_reg, out_valid_reg;

    logic [VALUE_W-1:0] num_next, abs_t, den_next;
    logic               s_ge_t, sat_next;
    logic [VALUE_W:0]   trial;
    logic [VALUE_W+1:0] diff;
    logic               qbit;
    logic [ERR_W-1:0]   err, max_next;
    logic               seen_next;

    // numerator: |sim - target| at full width, denominator by mode
    always_comb begin
        s_ge_t   = $signed(sim_reg) >= $signed(tgt_reg);
        num_next = s_ge_t ? (sim_reg - tgt_reg) : (tgt_reg - sim_reg);
        abs_t    = tgt_reg[VALUE_W-1] ? (~tgt_reg + 64'd1) : tgt_reg;
        if (mode_reg == MODE_EPSILON) begin
            den_next = abs_t + EPSILON_Q;
        end else begin
            den_next = (abs_t < {1'b0, floor_reg}) ? {1'b0, floor_reg} : abs_t;
        end
    end

    // quotient reaches 2^63 exactly when num >> 31 >= den; covers a zero denominator too
    assign sat_next = {31'd0, num_reg[VALUE_W-1:31]} >= den_reg;

    // one restoring step
    always_comb begin
        trial = {rem_reg, feed_reg[DIV_STEPS-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        qbit  = ~diff[VALUE_W+1];
    end

    // error of this item folded into the running state
    always_comb begin
        err       = sat_reg ? ERR_MAX : quo_reg;
        max_next  = (err > max_reg) ? err : max_reg;
        seen_next = seen_reg | sat_reg;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_EPSILON;
            floor_reg <= FLOOR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDX_MODE:  mode_reg  <= cfg_wr_data[0];
                CFG_IDX_FLOOR: floor_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // operand and divider registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sim_reg  <= in_sim;
            tgt_reg  <= in_target;
            last_reg <= in_last;
        end
        if (cmd.prep) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
        if (cmd.check) begin
            sat_reg  <= sat_next;
            rem_reg  <= {31'd0, num_reg[VALUE_W-1:31]};
            feed_reg <= {num_reg[30:0], 32'd0};
            quo_reg  <= '0;
            cnt_reg  <= CNT_W'(DIV_STEPS);
        end else if (cmd.step) begin
            rem_reg  <= qbit ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
            feed_reg <= {feed_reg[DIV_STEPS-2:0], 1'b0};
            quo_reg  <= {quo_reg[ERR_W-2:0], qbit};
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    // running max and saturation flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg  <= '0;
            seen_reg <= 1'b0;
        end else if (cmd.finish) begin
            if (last_reg) begin
                max_reg  <= '0;
                seen_reg <= 1'b0;
            end else begin
                max_reg  <= max_next;
                seen_reg <= seen_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && last_reg) begin
            out_error_reg <= max_next;
            out_sat_reg   <= seen_next;
        end
    end

    assign out_error = out_error_reg;
    assign out_sat   = out_sat_reg;
    assign out_valid = out_valid_reg;

    // status to the controller
    assign sts.sat_early = sat_next;
    assign sts.div_last  = (cnt_reg == CNT_W'(1));
    assign sts.last_item = last_reg;
    assign sts.out_busy  = out_valid_reg & ~out_ready;

endmodule

// ----- sv/max_relative_error_q32_top.sv -----
// top level of the streaming max relative error block, signed Q32.32
// depends on mre_pkg, mre_ctrl and mre_dp
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_       | in        | tdata: sim_value, target_value; tlast: last_element
//  m_       | out       | tdata: worst_error; tuser: saturated
//  cfg_     | in        | index 0 denominator_mode, index 1 denominator_floor
//
// each request passes through accept, operand set-up, overflow precheck,
// 63 steps of the one-bit restoring divider, then the max update; a request
// whose quotient saturates skips the divider and goes straight to the max update
// reset is synchronous and active low; no clearing pass is needed
// a result waits in the output register while the next request is taken;
// only a second result meeting a still-stalled output holds the block
module max_relative_error_q32_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [2*mre_pkg::VALUE_W-1:0]      s_tdata,   // [63:0] sim_value, [127:64] target_value
    input  logic                               s_tlast,   // last_element
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mre_pkg::ERR_W:0]            m_tdata,   // [62:0] worst_error, [63] zero
    output logic                               m_tuser,   // saturated
    input  logic                               cfg_wr_en,
    input  logic [mre_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mre_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import mre_pkg::*;

    mre_cmd_t         cmd;
    mre_sts_t         sts;
    logic [ERR_W-1:0] worst_error;

    // sequencing
    mre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and result storage
    mre_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_sim      (s_tdata[VALUE_W-1:0]),
        .in_target   (s_tdata[2*VALUE_W-1:VALUE_W]),
        .in_last     (s_tlast),
        .out_error   (worst_error),
        .out_sat     (m_tuser),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    assign m_tdata = {1'b0, worst_error};

endmodule
